// ===== src/clfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfp_pkg
// Shared character codes and the command/status bundles between the
// line parser controller and datapath.
// ----------------------------------------------------------------------------
package clfp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_DIG_0 = 8'd48;
    localparam logic [7:0] CHAR_DIG_9 = 8'd57;

    localparam logic SEL_TYPE = 1'b0;
    localparam logic SEL_TEMP = 1'b1;

    typedef struct packed {
        logic in_ready;
        logic store;
        logic rd_en;
        logic ptr_zero;
        logic ptr_inc;
        logic ptr_after_comma;
        logic cnt_clear;
        logic load_comma;
        logic clear_fill;
        logic emit;
        logic emit_sel;
        logic emit_zero;
        logic emit_last;
    } clfp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_is_lf;
        logic in_is_cr;
        logic fill_full;
        logic ptr_at_fill;
        logic ptr_at_comma;
        logic type_fits;
        logic field_done;
        logic rd_is_zero;
        logic rd_is_comma;
        logic rd_is_digit;
        logic out_free;
    } clfp_sts_t;

endpackage

// ===== src/clfp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfp_in_if / clfp_out_if
// Valid/ready channels for received bytes and parsed string characters.
// ----------------------------------------------------------------------------
interface clfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clfp_out_if;
    logic       valid;
    logic       ready;
    logic       string_select;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output string_select, output char_code, output last,
                    input ready);
    modport sink   (input valid, input string_select, input char_code, input last,
                    output ready);
endinterface

// ===== src/comma_line_field_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comma_line_field_parser
// Collects serial bytes into a line and emits the type and temperature
// strings found around the first comma when a newline arrives.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per item. Ordinary bytes are stored (up to
//   LINE_BYTES, extra ones dropped), carriage returns are ignored. A newline
//   starts a parse: the line memory is scanned byte by byte (registered
//   memory read, then check) to the first comma, then the type characters
//   are read again, unless the type is longer than FIELD_BYTES, and the
//   bytes after the comma (at most FIELD_BYTES) are read.
//   rx is not ready during the parse.
//   result carries one character per item, type string (string_select 0)
//   then temperature digits (string_select 1), each closed by a zero
//   character; last marks the final item of a line. A single output register
//   holds the pending item; when the receiver stalls the parse waits, and
//   after the last item is loaded rx is ready again at once.
//   Reset empties the line and the output register.
// ----------------------------------------------------------------------------
module comma_line_field_parser #(
    parameter int LINE_BYTES  = 31,
    parameter int FIELD_BYTES = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    clfp_in_if.sink    rx,
    clfp_out_if.source result
);
    import clfp_pkg::*;

    clfp_cmd_t cmd;
    clfp_sts_t sts;

    clfp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    clfp_datapath #(
        .LINE_BYTES  (LINE_BYTES),
        .FIELD_BYTES (FIELD_BYTES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .result (result),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

// ===== src/clfp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfp_datapath
// Line memory, fill count, scan pointer, comma position and the output
// register of the line parser.
// ----------------------------------------------------------------------------
module clfp_datapath #(
    parameter int LINE_BYTES  = 31,
    parameter int FIELD_BYTES = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    clfp_in_if.sink             rx,
    clfp_out_if.source          result,
    input  clfp_pkg::clfp_cmd_t cmd,
    output clfp_pkg::clfp_sts_t sts
);
    import clfp_pkg::*;

    localparam int FILL_W = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam int CNT_W  = $clog2(FIELD_BYTES + 1);

    logic [7:0]        line_mem [LINE_BYTES];
    logic [7:0]        rd_data_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] ptr_reg, ptr_next;
    logic [FILL_W-1:0] comma_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_sel_reg;
    logic [7:0]        out_char_reg;
    logic              out_last_reg;

    assign rx.ready             = cmd.in_ready;
    assign result.valid         = out_valid_reg;
    assign result.string_select = out_sel_reg;
    assign result.char_code     = out_char_reg;
    assign result.last          = out_last_reg;

    always_comb
    begin
        sts.in_valid     = rx.valid;
        sts.in_is_lf     = (rx.rx_byte == CHAR_LF);
        sts.in_is_cr     = (rx.rx_byte == CHAR_CR);
        sts.fill_full    = (fill_reg == FILL_W'(LINE_BYTES));
        sts.ptr_at_fill  = (ptr_reg == fill_reg);
        sts.ptr_at_comma = (ptr_reg == comma_reg);
        sts.type_fits    = ({{(32 - FILL_W){1'b0}}, ptr_reg} <= 32'(FIELD_BYTES));
        sts.field_done   = (cnt_reg == CNT_W'(FIELD_BYTES));
        sts.rd_is_zero   = (rd_data_reg == 8'd0);
        sts.rd_is_comma  = (rd_data_reg == CHAR_COMMA);
        sts.rd_is_digit  = (rd_data_reg >= CHAR_DIG_0) && (rd_data_reg <= CHAR_DIG_9);
        sts.out_free     = !out_valid_reg || result.ready;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear_fill)
            fill_next = '0;
        else if (cmd.store)
            fill_next = fill_reg + FILL_W'(1);

        ptr_next = ptr_reg;
        if (cmd.ptr_zero)
            ptr_next = '0;
        else if (cmd.ptr_after_comma)
            ptr_next = comma_reg + FILL_W'(1);
        else if (cmd.ptr_inc)
            ptr_next = ptr_reg + FILL_W'(1);

        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
            cnt_next = '0;
        else if (cmd.ptr_inc)
            cnt_next = cnt_reg + CNT_W'(1);

        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line memory: one write port at the fill count, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            line_mem[fill_reg[ADDR_W-1:0]] <= rx.rx_byte;
        if (cmd.rd_en)
            rd_data_reg <= line_mem[ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_comma)
            comma_reg <= ptr_reg;
        if (cmd.emit)
        begin
            out_sel_reg  <= cmd.emit_sel;
            out_char_reg <= cmd.emit_zero ? 8'd0 : rd_data_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

endmodule

// ===== src/clfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfp_ctrl
// Sequencer for the line parser: byte collection, comma scan, type string
// and temperature digit emission.
// ----------------------------------------------------------------------------
module clfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  clfp_pkg::clfp_sts_t sts,
    output clfp_pkg::clfp_cmd_t cmd
);
    import clfp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_TYPE_RD,
        ST_TYPE_CHK,
        ST_TYPE_END,
        ST_TEMP_RD,
        ST_TEMP_CHK,
        ST_TEMP_END
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    if (sts.in_is_lf)
                    begin
                        cmd.ptr_zero = 1'b1;
                        state_next   = ST_SCAN_RD;
                    end
                    else if (!sts.in_is_cr && !sts.fill_full)
                        cmd.store = 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.ptr_at_fill)
                begin
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                // text ends at a zero byte; no comma seen means no output
                if (sts.rd_is_zero)
                begin
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (sts.rd_is_comma)
                begin
                    cmd.load_comma = 1'b1;
                    if (sts.type_fits)
                    begin
                        cmd.ptr_zero = 1'b1;
                        state_next   = ST_TYPE_RD;
                    end
                    else
                    begin
                        cmd.ptr_inc   = 1'b1;
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_TEMP_RD;
                    end
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_TYPE_RD:
            begin
                if (sts.ptr_at_comma)
                    state_next = ST_TYPE_END;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_TYPE_CHK;
                end
            end
            ST_TYPE_CHK:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_TYPE;
                    cmd.ptr_inc  = 1'b1;
                    state_next   = ST_TYPE_RD;
                end
            end
            ST_TYPE_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit            = 1'b1;
                    cmd.emit_sel        = SEL_TYPE;
                    cmd.emit_zero       = 1'b1;
                    cmd.ptr_after_comma = 1'b1;
                    cmd.cnt_clear       = 1'b1;
                    state_next          = ST_TEMP_RD;
                end
            end
            ST_TEMP_RD:
            begin
                if (sts.ptr_at_fill || sts.field_done)
                    state_next = ST_TEMP_END;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_TEMP_CHK;
                end
            end
            ST_TEMP_CHK:
            begin
                if (sts.rd_is_zero)
                    state_next = ST_TEMP_END;
                else if (sts.rd_is_digit)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = SEL_TEMP;
                        cmd.ptr_inc  = 1'b1;
                        state_next   = ST_TEMP_RD;
                    end
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_TEMP_RD;
                end
            end
            ST_TEMP_END:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = SEL_TEMP;
                    cmd.emit_zero  = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
